### design/trs_pkg.sv
// trs_pkg: shared types, constants and saturating helpers for the relaxation solver
// no dependencies; imported by trs_muldiv, the top level and trs_checker
`default_nettype none
package trs_pkg;

  localparam int VW        = 48;                    // value width, signed Q16.32
  localparam int FRAC      = 32;                    // fraction bits
  localparam int MAX_INT   = 16;                    // interior node capacity
  localparam int IDX_W     = $clog2(MAX_INT);       // node address width
  localparam int CNT_W     = $clog2(MAX_INT + 1);   // node count width
  localparam int OIDX_W    = 5;                     // emitted node index width
  localparam int SW_W      = 16;                    // sweep counter width
  localparam int TOL_W     = 32;                    // tolerance width
  localparam int RIDX_W    = 3;                     // config register index width
  localparam int QW        = VW + FRAC;             // divider dividend width
  localparam int DIV_STEPS = QW;
  localparam int MUL_STEPS = VW;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  typedef logic signed [VW-1:0] val_t;

  typedef enum logic [RIDX_W-1:0] {
    REG_METHOD = 3'd0,
    REG_OFF    = 3'd1,
    REG_DIAG   = 3'd2,
    REG_LEFT   = 3'd3,
    REG_RIGHT  = 3'd4,
    REG_GUESS  = 3'd5,
    REG_TOL    = 3'd6,
    REG_CAP    = 3'd7
  } reg_idx_t;

  typedef enum logic {
    MD_MUL = 1'b0,
    MD_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_PRE,
    ST_PRE_LD,
    ST_RD,
    ST_SUM,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_WB,
    ST_SW_END,
    ST_E_RD,
    ST_E_SHOW,
    ST_E_WAIT
  } state_t;

  localparam val_t VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  // exact add, then clamp to the value range
  function automatic val_t add_sat(input val_t a, input val_t b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? VAL_MIN : VAL_MAX;
    end
    return val_t'(s[VW-1:0]);
  endfunction

  function automatic logic [VW-1:0] mag(input val_t a);
    return a[VW-1] ? (~a + 1'b1) : a;
  endfunction

endpackage
`default_nettype wire

### design/trs_ram.sv
// trs_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none
module trs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/trs_muldiv.sv
// trs_muldiv: shared bit-serial fractional multiplier and restoring divider
// depends on trs_pkg; mul gives sat(a*b >> 32), div gives sat((a << 32) / b)
`default_nettype none
module trs_muldiv import trs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire md_req_t req,
  input  wire val_t    a,
  input  wire val_t    b,
  output logic         done,
  output val_t         result
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  md_op_t            op_r, op_nxt;
  logic              neg_r, neg_nxt;
  logic              nz_r, nz_nxt;
  logic [VW:0]       rem_r, rem_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [VW-1:0]     m_r, m_nxt;

  logic [VW-1:0]     mag_a, mag_b;
  logic [VW:0]       sum, rt;
  logic              ge, last_step;
  logic [2*VW-1:0]   prod;
  logic [VW-1:0]     res_mag, lim;
  logic              over;

  assign mag_a = mag(a);
  assign mag_b = mag(b);
  assign sum   = {1'b0, rem_r[VW-1:0]} + (q_r[0] ? {1'b0, m_r} : '0);
  assign rt    = {rem_r[VW-1:0], q_r[QW-1]};
  assign ge    = rt >= {1'b0, m_r};
  assign last_step = (op_r == MD_MUL) ? (cnt_r == STEP_W'(MUL_STEPS - 1))
                                      : (cnt_r == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    nz_nxt   = nz_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    m_nxt    = m_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      op_nxt   = req.op;
      neg_nxt  = a[VW-1] ^ b[VW-1];
      nz_nxt   = (mag_a == '0);
      rem_nxt  = '0;
      if (req.op == MD_MUL) begin
        m_nxt = mag_a;
        q_nxt = {{FRAC{1'b0}}, mag_b};
      end else begin
        m_nxt = mag_b;
        q_nxt = {mag_a, {FRAC{1'b0}}};
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (op_r == MD_MUL) begin
        rem_nxt = {1'b0, sum[VW:1]};
        q_nxt   = {q_r[QW-1:VW], sum[0], q_r[VW-1:1]};
      end else begin
        rem_nxt = ge ? (rt - {1'b0, m_r}) : rt;
        q_nxt   = {q_r[QW-2:0], ge};
      end
      if (last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    nz_r  <= nz_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    m_r   <= m_nxt;
  end

  // product is {rem, q} after the last shift; keep bits from FRAC upward
  assign prod = {rem_r[VW-1:0], q_r[VW-1:0]};
  assign lim  = neg_r ? VAL_MIN : VAL_MAX;

  always_comb begin
    if (op_r == MD_MUL) begin
      over    = (|prod[2*VW-1:VW+FRAC]) || (prod[VW+FRAC-1:FRAC] > lim);
      res_mag = prod[VW+FRAC-1:FRAC];
    end else begin
      over    = (|q_r[QW-1:VW]) || (q_r[VW-1:0] > lim);
      res_mag = q_r[VW-1:0];
    end
    if (over) begin
      res_mag = lim;
    end
    if (nz_r) begin
      result = '0;
    end else begin
      result = neg_r ? val_t'(~res_mag + 1'b1) : val_t'(res_mag);
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

### design/tridiagonal_relaxation_solver.sv
// tridiagonal_relaxation_solver: top level, loader, sweep sequencer and result emitter
// depends on trs_pkg, trs_ram and trs_muldiv
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_ready   source_value, last_node
//  out_     output     out_valid / out_ready node_index, node_value, sweep_count,
//                                            converged, overflow, last_result
//  cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// loading accepts one source term per cycle; in_ready is low from the last-node
// transaction until the right-boundary result has been taken.
// solve: guess fill of all n nodes, then sweeps, each node of a sweep taking one multiply
// and then one divide on the one shared mul/div unit.
// emit: each result is read, shown and then held until out_ready takes it.
// reset (rst_n low, synchronous) restores the register defaults and idles the block.
`default_nettype none
module tridiagonal_relaxation_solver import trs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [VW-1:0]     in_source_value,
  input  wire logic              in_last_node,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OIDX_W-1:0]      out_node_index,
  output logic [VW-1:0]          out_node_value,
  output logic [SW_W-1:0]        out_sweep_count,
  output logic                   out_converged,
  output logic                   out_overflow,
  output logic                   out_last_result,
  input  wire logic              cfg_we,
  input  wire logic [RIDX_W-1:0] cfg_index,
  input  wire logic [VW-1:0]     cfg_wdata
);

  // configuration
  logic             method_r;
  val_t             off_r, diag_r, left_r, right_r, guess_r;
  logic [TOL_W-1:0] tol_r;
  logic [SW_W-1:0]  cap_r;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              ovf_r, ovf_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [OIDX_W-1:0] k_r, k_nxt;
  logic [SW_W-1:0]   sweep_r, sweep_nxt;
  logic              all_r, all_nxt;
  logic              conv_r, conv_nxt;
  val_t              left_nb_r, left_nb_nxt;
  val_t              cur_old_r, cur_old_nxt;
  val_t              nxt_old_r, nxt_old_nxt;
  val_t              src_r, src_nxt;
  val_t              sum_r, sum_nxt;
  val_t              acc_r, acc_nxt;
  val_t              xnew_r, xnew_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OIDX_W-1:0] oidx_r, oidx_nxt;
  val_t              oval_r, oval_nxt;
  logic [SW_W-1:0]   osw_r, osw_nxt;
  logic              oconv_r, oconv_nxt, oovf_r, oovf_nxt, olast_r, olast_nxt;

  // memories
  logic             x_we, s_we;
  logic [IDX_W-1:0] x_waddr, x_raddr, s_waddr, s_raddr;
  val_t             x_wdata, s_wdata;
  logic [VW-1:0]    x_rdata, s_rdata;

  // shared unit
  md_req_t md_req;
  val_t    md_a, md_b, md_res;
  logic    md_done;

  logic             in_acc, out_acc, last_i;
  logic [SW_W-1:0]  sweep_inc;
  logic [VW:0]      diff;
  logic [VW-1:0]    adiff;
  val_t             right_val;

  trs_ram #(.WIDTH(VW), .DEPTH(MAX_INT)) u_xmem (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(x_raddr), .rdata(x_rdata)
  );

  trs_ram #(.WIDTH(VW), .DEPTH(MAX_INT)) u_smem (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  trs_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .req(md_req), .a(md_a), .b(md_b),
    .done(md_done), .result(md_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= 1'b0;
      off_r    <= -val_t'(64'sd429496729600);
      diag_r   <= -val_t'(64'sd876173328384);
      left_r   <= '0;
      right_r  <= val_t'(64'sd4294967296);
      guess_r  <= val_t'(64'sd2147483648);
      tol_r    <= TOL_W'(42950);
      cap_r    <= SW_W'(65535);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_METHOD: method_r <= cfg_wdata[0];
        REG_OFF:    off_r    <= val_t'(cfg_wdata);
        REG_DIAG:   diag_r   <= val_t'(cfg_wdata);
        REG_LEFT:   left_r   <= val_t'(cfg_wdata);
        REG_RIGHT:  right_r  <= val_t'(cfg_wdata);
        REG_GUESS:  guess_r  <= val_t'(cfg_wdata);
        REG_TOL:    tol_r    <= cfg_wdata[TOL_W-1:0];
        REG_CAP:    cap_r    <= cfg_wdata[SW_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid_r && out_ready;
  assign last_i    = ({1'b0, idx_r} == (n_r - 1'b1));
  assign sweep_inc = sweep_r + 1'b1;
  assign right_val = last_i ? right_r : val_t'(x_rdata);
  assign diff      = {xnew_r[VW-1], xnew_r} - {cur_old_r[VW-1], cur_old_r};
  assign adiff     = diff[VW] ? VW'(~diff + 1'b1) : diff[VW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_acc && in_last_node) state_nxt = ST_INIT;
      ST_INIT:     if (last_i) state_nxt = ST_PRE;
      ST_PRE:      state_nxt = ST_PRE_LD;
      ST_PRE_LD:   state_nxt = ST_RD;
      ST_RD:       state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_MUL_GO;
      ST_MUL_GO:   state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: if (md_done) state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (md_done) state_nxt = ST_WB;
      ST_WB:       state_nxt = last_i ? ST_SW_END : ST_RD;
      ST_SW_END: begin
        if (all_r || (sweep_inc >= cap_r)) state_nxt = ST_E_RD;
        else state_nxt = ST_PRE;
      end
      ST_E_RD:     state_nxt = ST_E_SHOW;
      ST_E_SHOW:   state_nxt = ST_E_WAIT;
      ST_E_WAIT: begin
        if (out_acc) state_nxt = olast_r ? ST_IDLE : ST_E_RD;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    count_nxt     = count_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    sweep_nxt     = sweep_r;
    all_nxt       = all_r;
    conv_nxt      = conv_r;
    left_nb_nxt   = left_nb_r;
    cur_old_nxt   = cur_old_r;
    nxt_old_nxt   = nxt_old_r;
    src_nxt       = src_r;
    sum_nxt       = sum_r;
    acc_nxt       = acc_r;
    xnew_nxt      = xnew_r;
    out_valid_nxt = out_valid_r;
    oidx_nxt      = oidx_r;
    oval_nxt      = oval_r;
    osw_nxt       = osw_r;
    oconv_nxt     = oconv_r;
    oovf_nxt      = oovf_r;
    olast_nxt     = olast_r;
    in_ready      = 1'b0;
    x_we          = 1'b0;
    x_waddr       = idx_r;
    x_wdata       = xnew_r;
    x_raddr       = idx_r + 1'b1;
    s_we          = 1'b0;
    s_waddr       = count_r[IDX_W-1:0];
    s_wdata       = val_t'(in_source_value);
    s_raddr       = idx_r;
    md_req.start  = 1'b0;
    md_req.op     = MD_MUL;
    md_a          = off_r;
    md_b          = sum_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (count_r < CNT_W'(MAX_INT)) begin
            s_we      = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_node) begin
            n_nxt     = (count_r < CNT_W'(MAX_INT)) ? count_r + 1'b1 : count_r;
            idx_nxt   = '0;
            sweep_nxt = '0;
          end
        end
      end
      ST_INIT: begin
        x_we    = 1'b1;
        x_wdata = guess_r;
        idx_nxt = last_i ? '0 : idx_r + 1'b1;
      end
      ST_PRE: begin
        x_raddr = '0;
      end
      ST_PRE_LD: begin
        cur_old_nxt = val_t'(x_rdata);
        left_nb_nxt = left_r;
        idx_nxt     = '0;
        all_nxt     = 1'b1;
      end
      ST_SUM: begin
        nxt_old_nxt = right_val;
        src_nxt     = val_t'(s_rdata);
        sum_nxt     = add_sat(left_nb_r, right_val);
      end
      ST_MUL_GO: begin
        md_req.start = 1'b1;
      end
      ST_MUL_WAIT: begin
        if (md_done) acc_nxt = add_sat(md_res, src_r);
      end
      ST_DIV_GO: begin
        md_req.start = 1'b1;
        md_req.op    = MD_DIV;
        md_a         = acc_r;
        md_b         = diag_r;
      end
      ST_DIV_WAIT: begin
        md_req.op = MD_DIV;
        md_a      = acc_r;
        md_b      = diag_r;
        if (md_done) xnew_nxt = md_res;
      end
      ST_WB: begin
        x_we = 1'b1;
        if (adiff >= {{(VW-TOL_W){1'b0}}, tol_r}) all_nxt = 1'b0;
        // gauss-seidel feeds the fresh value to the next node
        left_nb_nxt = method_r ? xnew_r : cur_old_r;
        cur_old_nxt = nxt_old_r;
        if (!last_i) idx_nxt = idx_r + 1'b1;
      end
      ST_SW_END: begin
        sweep_nxt = sweep_inc;
        conv_nxt  = all_r;
        k_nxt     = '0;
      end
      ST_E_RD: begin
        x_raddr = IDX_W'(k_r - 1'b1);
      end
      ST_E_SHOW: begin
        out_valid_nxt = 1'b1;
        oidx_nxt      = k_r;
        if (k_r == '0) oval_nxt = left_r;
        else if (k_r == OIDX_W'(n_r + 1'b1)) oval_nxt = right_r;
        else oval_nxt = val_t'(x_rdata);
        osw_nxt   = sweep_r;
        oconv_nxt = conv_r;
        oovf_nxt  = ovf_r;
        olast_nxt = (k_r == OIDX_W'(n_r + 1'b1));
      end
      ST_E_WAIT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_r + 1'b1;
          if (olast_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            sweep_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r       <= n_nxt;
    idx_r     <= idx_nxt;
    k_r       <= k_nxt;
    all_r     <= all_nxt;
    conv_r    <= conv_nxt;
    left_nb_r <= left_nb_nxt;
    cur_old_r <= cur_old_nxt;
    nxt_old_r <= nxt_old_nxt;
    src_r     <= src_nxt;
    sum_r     <= sum_nxt;
    acc_r     <= acc_nxt;
    xnew_r    <= xnew_nxt;
    oidx_r    <= oidx_nxt;
    oval_r    <= oval_nxt;
    osw_r     <= osw_nxt;
    oconv_r   <= oconv_nxt;
    oovf_r    <= oovf_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_node_index  = oidx_r;
  assign out_node_value  = oval_r;
  assign out_sweep_count = osw_r;
  assign out_converged   = oconv_r;
  assign out_overflow    = oovf_r;
  assign out_last_result = olast_r;

endmodule
`default_nettype wire

### design/trs_checker.sv
// trs_checker: port-level assertions for the relaxation solver, bound to the top level
// depends on trs_pkg
`default_nettype none
module trs_checker import trs_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_last_node,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [OIDX_W-1:0] out_node_index,
  input wire logic [VW-1:0]     out_node_value,
  input wire logic              out_last_result
);

  // no loading while results are being delivered
  a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("in_ready high while a result is shown");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_value)
      && $stable(out_node_index)) else $error("stalled result changed");

  // a non-final source term keeps the loader open
  a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_node |=> in_ready)
    else $error("loader closed without last node");

  // the final transaction of a run returns the block to loading
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> in_ready && !out_valid)
    else $error("block not idle after right boundary");

  // the left boundary is never the last result
  a_left_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_node_index == '0) |-> !out_last_result)
    else $error("left boundary flagged as last");

endmodule

bind tridiagonal_relaxation_solver trs_checker u_trs_checker (.*);
`default_nettype wire
